/* hdl/csc_pkg.sv */
package csc_pkg;

	localparam int CFG_INDEX_WIDTH = 3;
	localparam int CFG_DATA_WIDTH  = 16;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_TARGET_CM         = 3'd0,
		REG_DEAD_ZONE_CM      = 3'd1,
		REG_FRONT_OFFSET_CM   = 3'd2,
		REG_OVERRIDE_DELAY_MS = 3'd3,
		REG_STEP_INTERVAL_US  = 3'd4,
		REG_BACKOFF_COUNT     = 3'd5
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MOTION_STABLE = 2'd0,
		MOTION_DOWN   = 2'd1,
		MOTION_UP     = 2'd2
	} motion_t;

	typedef struct packed {
		logic [5:0]  target_cm;
		logic [3:0]  dead_zone_cm;
		logic [7:0]  front_offset_cm;
		logic [15:0] override_delay_ms;
		logic [15:0] step_interval_us;
		logic [7:0]  backoff_count;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		target_cm:         6'd10,
		dead_zone_cm:      4'd1,
		front_offset_cm:   8'd3,
		override_delay_ms: 16'd5000,
		step_interval_us:  16'd2500,
		backoff_count:     8'd10
	};

	localparam logic [5:0] TARGET_MIN = 6'd1;
	localparam logic [5:0] TARGET_MAX = 6'd49;

	// queue entry at the default field widths
	typedef struct packed {
		logic        front_valid;
		logic [15:0] front_cm;
		logic [15:0] front_cal;
		logic        rear_valid;
		logic [15:0] rear_cm;
		logic        home_pressed;
		logic        emergency;
		logic [31:0] time_us;
		logic [31:0] time_ms;
	} item_def_t;

endpackage

/* hdl/csc_sample_if.sv */
interface csc_sample_if #(
	parameter int DIST_WIDTH = 16,
	parameter int TIME_WIDTH = 32
);
	logic                  valid;
	logic                  ready;
	logic                  front_valid;
	logic [DIST_WIDTH-1:0] front_cm;
	logic                  rear_valid;
	logic [DIST_WIDTH-1:0] rear_cm;
	logic                  home_pressed;
	logic                  emergency;
	logic [TIME_WIDTH-1:0] time_us;
	logic [TIME_WIDTH-1:0] time_ms;

	modport source (
		output valid, front_valid, front_cm, rear_valid, rear_cm, home_pressed,
		       emergency, time_us, time_ms,
		input  ready
	);
	modport sink (
		input  valid, front_valid, front_cm, rear_valid, rear_cm, home_pressed,
		       emergency, time_us, time_ms,
		output ready
	);
endinterface

/* hdl/csc_result_if.sv */
interface csc_result_if #(
	parameter int DIST_WIDTH = 16
);
	logic                  valid;
	logic                  ready;
	logic                  step_pulse;
	logic                  step_down;
	logic [1:0]            motion;
	logic                  override_on;
	logic                  emergency_on;
	logic                  is_homed;
	logic                  fused_valid;
	logic [DIST_WIDTH-1:0] fused_cm;

	modport source (
		output valid, step_pulse, step_down, motion, override_on, emergency_on,
		       is_homed, fused_valid, fused_cm,
		input  ready
	);
	modport sink (
		input  valid, step_pulse, step_down, motion, override_on, emergency_on,
		       is_homed, fused_valid, fused_cm,
		output ready
	);
endinterface

/* hdl/csc_cfg_if.sv */
interface csc_cfg_if
	import csc_pkg::*;
();
	logic                       valid;
	logic                       ready;
	logic [CFG_INDEX_WIDTH-1:0] index;
	logic [CFG_DATA_WIDTH-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* hdl/csc_front.sv */
module csc_front
	import csc_pkg::*;
#(
	parameter int DIST_WIDTH = 16,
	parameter int TIME_WIDTH = 32,
	parameter type item_t = item_def_t
) (
	csc_sample_if.sink sample,
	input  cfg_t       cfg,
	input  logic       full,
	output logic       push,
	output item_t      item
);
	logic [DIST_WIDTH-1:0] offset;

	assign offset       = DIST_WIDTH'(cfg.front_offset_cm);
	assign sample.ready = !full;
	assign push         = sample.valid && !full;

	always_comb begin
		item              = '0;
		item.front_valid  = sample.front_valid;
		item.front_cm     = sample.front_cm;
		// calibrated front reading, clamped at zero
		item.front_cal    = (sample.front_cm > offset) ? (sample.front_cm - offset) : '0;
		item.rear_valid   = sample.rear_valid;
		item.rear_cm      = sample.rear_cm;
		item.home_pressed = sample.home_pressed;
		item.emergency    = sample.emergency;
		item.time_us      = sample.time_us;
		item.time_ms      = sample.time_ms;
	end
endmodule

/* hdl/csc_fifo.sv */
module csc_fifo
	import csc_pkg::*;
#(
	parameter int DEPTH = 2,
	parameter type item_t = item_def_t
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output item_t pop_item,
	output logic  full,
	output logic  empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t         mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end
endmodule

/* hdl/csc_back.sv */
module csc_back
	import csc_pkg::*;
#(
	parameter int DIST_WIDTH = 16,
	parameter int TIME_WIDTH = 32,
	parameter type item_t = item_def_t
) (
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_t         cfg,
	input  logic         empty,
	input  item_t        item,
	output logic         pop,
	csc_result_if.source result
);
	logic                  homed_q, homed_n;
	logic                  in_backoff_q, in_backoff_n;
	logic [7:0]            backoff_done_q, backoff_done_n;
	logic [TIME_WIDTH-1:0] last_step_us_q, last_step_us_n;
	logic [DIST_WIDTH-1:0] held_front_q, held_front_n;
	logic                  held_front_ok_q, held_front_ok_n;
	logic [DIST_WIDTH-1:0] held_rear_q, held_rear_n;
	logic                  held_rear_ok_q, held_rear_ok_n;
	logic                  timing_above_q, timing_above_n;
	logic [TIME_WIDTH-1:0] above_start_ms_q, above_start_ms_n;
	logic                  override_q, override_n;
	motion_t               motion_q, motion_n;

	logic                  res_valid_q;
	logic                  res_pulse_q;
	logic                  res_down_q;
	motion_t               res_motion_q;
	logic                  res_override_q;
	logic                  res_emerg_q;
	logic                  res_homed_q;
	logic                  res_fv_q;
	logic [DIST_WIDTH-1:0] res_fused_q;

	logic                  pulse;
	logic                  down;
	logic                  fv;
	logic                  emerg_on;
	logic                  above;
	logic                  rate_ok;
	logic [7:0]            done_inc;
	logic [DIST_WIDTH-1:0] offset;
	logic [DIST_WIDTH-1:0] held_cal;
	logic [DIST_WIDTH-1:0] cal;
	logic [DIST_WIDTH-1:0] fused;
	logic [6:0]            upper_cm;
	logic [DIST_WIDTH:0]   lower_sum;

	assign pop = !empty && (!res_valid_q || result.ready);

	assign offset    = DIST_WIDTH'(cfg.front_offset_cm);
	assign held_cal  = (held_front_q > offset) ? (held_front_q - offset) : '0;
	assign rate_ok   = (item.time_us - last_step_us_q) >= TIME_WIDTH'(cfg.step_interval_us);
	assign done_inc  = backoff_done_q + 8'd1;
	assign upper_cm  = 7'(cfg.target_cm) + 7'(cfg.dead_zone_cm);
	assign lower_sum = {1'b0, fused} + (DIST_WIDTH + 1)'(cfg.dead_zone_cm);

	always_comb begin
		homed_n          = homed_q;
		in_backoff_n     = in_backoff_q;
		backoff_done_n   = backoff_done_q;
		last_step_us_n   = last_step_us_q;
		held_front_n     = held_front_q;
		held_front_ok_n  = held_front_ok_q;
		held_rear_n      = held_rear_q;
		held_rear_ok_n   = held_rear_ok_q;
		timing_above_n   = timing_above_q;
		above_start_ms_n = above_start_ms_q;
		override_n       = override_q;
		motion_n         = motion_q;
		pulse            = 1'b0;
		down             = 1'b0;
		fv               = 1'b0;
		emerg_on         = 1'b0;
		above            = 1'b0;
		cal              = '0;
		fused            = '0;

		if (!homed_q) begin
			if (!in_backoff_q) begin
				if (item.home_pressed) begin
					in_backoff_n   = 1'b1;
					backoff_done_n = '0;
					if (cfg.backoff_count == '0) begin
						homed_n      = 1'b1;
						in_backoff_n = 1'b0;
					end
				end else if (rate_ok) begin
					pulse = 1'b1;
				end
			end else if (rate_ok) begin
				pulse          = 1'b1;
				down           = 1'b1;
				backoff_done_n = done_inc;
				if (done_inc >= cfg.backoff_count) begin
					homed_n      = 1'b1;
					in_backoff_n = 1'b0;
				end
			end
		end else if (item.emergency) begin
			emerg_on = 1'b1;
			if (!item.home_pressed && rate_ok) begin
				pulse = 1'b1;
			end
		end else begin
			if (item.front_valid) begin
				held_front_n    = item.front_cm;
				held_front_ok_n = 1'b1;
			end
			if (item.rear_valid) begin
				held_rear_n    = item.rear_cm;
				held_rear_ok_n = 1'b1;
			end
			cal = item.front_valid ? item.front_cal : held_cal;
			if (held_front_ok_n && held_rear_ok_n) begin
				fused = (cal < held_rear_n) ? cal : held_rear_n;
				fv    = 1'b1;
			end else if (held_front_ok_n) begin
				fused = cal;
				fv    = 1'b1;
			end else if (held_rear_ok_n) begin
				fused = held_rear_n;
				fv    = 1'b1;
			end
			if (fv) begin
				above = fused > DIST_WIDTH'(cfg.target_cm);
				if (above) begin
					if (!timing_above_q) begin
						timing_above_n   = 1'b1;
						above_start_ms_n = item.time_ms;
					end else if ((item.time_ms - above_start_ms_q) >=
					             TIME_WIDTH'(cfg.override_delay_ms)) begin
						override_n = 1'b1;
					end
				end else begin
					timing_above_n = 1'b0;
					override_n     = 1'b0;
				end
				if (override_n && above) begin
					motion_n = MOTION_DOWN;
					if (rate_ok) begin
						pulse = 1'b1;
						down  = 1'b1;
					end
				end else if (fused > DIST_WIDTH'(upper_cm)) begin
					motion_n = MOTION_DOWN;
					if (rate_ok) begin
						pulse = 1'b1;
						down  = 1'b1;
					end
				end else if (lower_sum < (DIST_WIDTH + 1)'(cfg.target_cm)) begin
					if (!item.home_pressed) begin
						motion_n = MOTION_UP;
						if (rate_ok) begin
							pulse = 1'b1;
						end
					end
				end else begin
					motion_n = MOTION_STABLE;
				end
			end
		end

		if (pulse) begin
			last_step_us_n = item.time_us;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			homed_q          <= 1'b0;
			in_backoff_q     <= 1'b0;
			backoff_done_q   <= '0;
			last_step_us_q   <= '0;
			held_front_q     <= '0;
			held_front_ok_q  <= 1'b0;
			held_rear_q      <= '0;
			held_rear_ok_q   <= 1'b0;
			timing_above_q   <= 1'b0;
			above_start_ms_q <= '0;
			override_q       <= 1'b0;
			motion_q         <= MOTION_STABLE;
			res_valid_q      <= 1'b0;
		end else begin
			if (pop) begin
				homed_q          <= homed_n;
				in_backoff_q     <= in_backoff_n;
				backoff_done_q   <= backoff_done_n;
				last_step_us_q   <= last_step_us_n;
				held_front_q     <= held_front_n;
				held_front_ok_q  <= held_front_ok_n;
				held_rear_q      <= held_rear_n;
				held_rear_ok_q   <= held_rear_ok_n;
				timing_above_q   <= timing_above_n;
				above_start_ms_q <= above_start_ms_n;
				override_q       <= override_n;
				motion_q         <= motion_n;
				res_valid_q      <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_pulse_q    <= pulse;
			res_down_q     <= pulse && down;
			res_motion_q   <= motion_n;
			res_override_q <= override_n;
			res_emerg_q    <= emerg_on;
			res_homed_q    <= homed_n;
			res_fv_q       <= fv;
			res_fused_q    <= fv ? fused : '0;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.step_pulse   = res_pulse_q;
	assign result.step_down    = res_down_q;
	assign result.motion       = res_motion_q;
	assign result.override_on  = res_override_q;
	assign result.emergency_on = res_emerg_q;
	assign result.is_homed     = res_homed_q;
	assign result.fused_valid  = res_fv_q;
	assign result.fused_cm     = res_fused_q;
endmodule

/* hdl/clearance_stepper_controller.sv */
// clearance stepper controller
// sample channel: one beat per sensor sample with both distance readings and
// their valid flags, the home and emergency switches and the us/ms timestamps.
// result channel: exactly one beat per sample beat, in order, with the step
// pulse, its direction, motion state, override/emergency/homed flags and the
// fused clearance.
// cfg channel: one register write per beat, always ready; write only while
// no sample is in flight. target_cm writes whose low six bits lie outside 1..49 are dropped.
// throughput: one sample per cycle while results are taken; the back end
// updates all control state for one sample on its pop, so a new beat can
// follow every cycle.
// a two-entry queue sits between the front end and the back end, and the
// result is held in an output register, so a stalled receiver fills the queue
// before sample ready drops; nothing is lost or repeated.
// reset: the block starts unhomed, with registers at their defaults, and the
// queue and result register empty.
module clearance_stepper_controller
	import csc_pkg::*;
#(
	parameter int DIST_WIDTH = 16,
	parameter int TIME_WIDTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	csc_sample_if.sink   sample,
	csc_result_if.source result,
	csc_cfg_if.sink      cfg
);
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic                  front_valid;
		logic [DIST_WIDTH-1:0] front_cm;
		logic [DIST_WIDTH-1:0] front_cal;
		logic                  rear_valid;
		logic [DIST_WIDTH-1:0] rear_cm;
		logic                  home_pressed;
		logic                  emergency;
		logic [TIME_WIDTH-1:0] time_us;
		logic [TIME_WIDTH-1:0] time_ms;
	} item_t;

	cfg_t  cfg_q;
	logic  push;
	logic  pop;
	logic  full;
	logic  empty;
	item_t push_item;
	item_t pop_item;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg.valid) begin
			unique case (cfg_idx_t'(cfg.index))
				REG_TARGET_CM: begin
					if (cfg.data[5:0] >= TARGET_MIN && cfg.data[5:0] <= TARGET_MAX) begin
						cfg_q.target_cm <= cfg.data[5:0];
					end
				end
				REG_DEAD_ZONE_CM:      cfg_q.dead_zone_cm      <= cfg.data[3:0];
				REG_FRONT_OFFSET_CM:   cfg_q.front_offset_cm   <= cfg.data[7:0];
				REG_OVERRIDE_DELAY_MS: cfg_q.override_delay_ms <= cfg.data[15:0];
				REG_STEP_INTERVAL_US:  cfg_q.step_interval_us  <= cfg.data[15:0];
				REG_BACKOFF_COUNT:     cfg_q.backoff_count     <= cfg.data[7:0];
				default: begin
				end
			endcase
		end
	end

	csc_front #(
		.DIST_WIDTH(DIST_WIDTH),
		.TIME_WIDTH(TIME_WIDTH),
		.item_t    (item_t)
	) u_front (
		.sample(sample),
		.cfg   (cfg_q),
		.full  (full),
		.push  (push),
		.item  (push_item)
	);

	csc_fifo #(
		.DEPTH (QUEUE_DEPTH),
		.item_t(item_t)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.pop_item (pop_item),
		.full     (full),
		.empty    (empty)
	);

	csc_back #(
		.DIST_WIDTH(DIST_WIDTH),
		.TIME_WIDTH(TIME_WIDTH),
		.item_t    (item_t)
	) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_q),
		.empty (empty),
		.item  (pop_item),
		.pop   (pop),
		.result(result)
	);
endmodule

/* bench/clearance_stepper_controller_test.sv */
module clearance_stepper_controller_test;
	import csc_pkg::*;

	localparam int STALL_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_ITEMS  = 125;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNMAPPED = 3'd7;

	typedef struct {
		logic        front_valid;
		logic [15:0] front_cm;
		logic        rear_valid;
		logic [15:0] rear_cm;
		logic        home_pressed;
		logic        emergency;
		logic [31:0] time_us;
		logic [31:0] time_ms;
	} sample_t;

	typedef struct {
		logic        step_pulse;
		logic        step_down;
		motion_t     motion;
		logic        override_on;
		logic        emergency_on;
		logic        is_homed;
		logic        fused_valid;
		logic [15:0] fused_cm;
	} step_result_t;

	logic clk = 1'b0;
	logic arst_n;

	csc_sample_if #(.DIST_WIDTH(16), .TIME_WIDTH(32)) smp ();
	csc_result_if #(.DIST_WIDTH(16)) res ();
	csc_cfg_if cfg_ch ();

	clearance_stepper_controller #(.DIST_WIDTH(16), .TIME_WIDTH(32)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(smp),
		.result(res),
		.cfg(cfg_ch)
	);

	// shadow of the controller state and registers
	cfg_t        regs_shadow    = CFG_RESET;
	logic        homed_q        = 1'b0;
	logic        backoff_active = 1'b0;
	logic [7:0]  backoff_taken  = 8'd0;
	logic [31:0] last_pulse_us  = 32'd0;
	logic [15:0] front_held     = 16'd0;
	logic        front_ok_q     = 1'b0;
	logic [15:0] rear_held      = 16'd0;
	logic        rear_ok_q      = 1'b0;
	logic        above_timing   = 1'b0;
	logic [31:0] above_since_ms = 32'd0;
	logic        override_q     = 1'b0;
	motion_t     motion_q       = MOTION_STABLE;

	sample_t      sample_q[$];
	step_result_t clearance_q[$];

	int mismatches   = 0;
	int stall_cycles = 0;
	bit smp_fire     = 1'b0;
	bit no_idle      = 1'b0;
	int hold_asks    = 0;
	int hold_seen    = 0;
	int hold_left    = 0;

	logic [31:0] us_now;
	logic [31:0] ms_now;
	int          level;
	int          em_left;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic pulse_due(logic [31:0] now_us);
		if (now_us - last_pulse_us >= {16'd0, regs_shadow.step_interval_us}) begin
			last_pulse_us = now_us;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic step_result_t predict_step(sample_t s);
		step_result_t r;
		logic [15:0] cal;
		logic above;
		r.step_pulse = 1'b0;
		r.step_down = 1'b0;
		r.emergency_on = 1'b0;
		r.fused_valid = 1'b0;
		r.fused_cm = 16'd0;
		if (!homed_q) begin
			if (!backoff_active) begin
				if (s.home_pressed) begin
					backoff_active = 1'b1;
					backoff_taken = 8'd0;
					if (regs_shadow.backoff_count == 8'd0) begin
						homed_q = 1'b1;
						backoff_active = 1'b0;
					end
				end else if (pulse_due(s.time_us)) begin
					r.step_pulse = 1'b1;
				end
			end else if (pulse_due(s.time_us)) begin
				r.step_pulse = 1'b1;
				r.step_down = 1'b1;
				backoff_taken = backoff_taken + 8'd1;
				if (backoff_taken >= regs_shadow.backoff_count) begin
					homed_q = 1'b1;
					backoff_active = 1'b0;
				end
			end
		end else if (s.emergency) begin
			r.emergency_on = 1'b1;
			if (!s.home_pressed) begin
				if (pulse_due(s.time_us))
					r.step_pulse = 1'b1;
			end
		end else begin
			if (s.front_valid) begin
				front_held = s.front_cm;
				front_ok_q = 1'b1;
			end
			if (s.rear_valid) begin
				rear_held = s.rear_cm;
				rear_ok_q = 1'b1;
			end
			cal = (front_held > {8'd0, regs_shadow.front_offset_cm}) ?
				front_held - {8'd0, regs_shadow.front_offset_cm} : 16'd0;
			if (front_ok_q && rear_ok_q) begin
				r.fused_cm = (cal < rear_held) ? cal : rear_held;
				r.fused_valid = 1'b1;
			end else if (front_ok_q) begin
				r.fused_cm = cal;
				r.fused_valid = 1'b1;
			end else if (rear_ok_q) begin
				r.fused_cm = rear_held;
				r.fused_valid = 1'b1;
			end
			if (r.fused_valid) begin
				above = r.fused_cm > {10'd0, regs_shadow.target_cm};
				if (above) begin
					if (!above_timing) begin
						above_timing = 1'b1;
						above_since_ms = s.time_ms;
					end else if (s.time_ms - above_since_ms >=
							{16'd0, regs_shadow.override_delay_ms}) begin
						override_q = 1'b1;
					end
				end else begin
					above_timing = 1'b0;
					override_q = 1'b0;
				end
				if ((override_q && above) || {1'b0, r.fused_cm} >
						{11'd0, regs_shadow.target_cm} + {13'd0, regs_shadow.dead_zone_cm}) begin
					motion_q = MOTION_DOWN;
					if (pulse_due(s.time_us)) begin
						r.step_pulse = 1'b1;
						r.step_down = 1'b1;
					end
				end else if ({1'b0, r.fused_cm} + {13'd0, regs_shadow.dead_zone_cm} <
						{11'd0, regs_shadow.target_cm}) begin
					if (!s.home_pressed) begin
						motion_q = MOTION_UP;
						if (pulse_due(s.time_us))
							r.step_pulse = 1'b1;
					end
				end else begin
					motion_q = MOTION_STABLE;
				end
			end
		end
		r.motion = motion_q;
		r.override_on = override_q;
		r.is_homed = homed_q;
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	// monitor: checks result beats, predicts accepted sample beats
	always @(posedge clk) begin
		step_result_t want;
		smp_fire = arst_n && smp.valid && smp.ready;
		if (arst_n) begin
			if (res.valid && res.ready) begin
				if (clearance_q.size() == 0) begin
					$error("result beat with no expected result");
					mismatches++;
				end else begin
					want = clearance_q.pop_front();
					check_field("step_pulse", 32'(want.step_pulse), 32'(res.step_pulse));
					check_field("step_down", 32'(want.step_down), 32'(res.step_down));
					check_field("motion", 32'(want.motion), 32'(res.motion));
					check_field("override_on", 32'(want.override_on), 32'(res.override_on));
					check_field("emergency_on", 32'(want.emergency_on),
						32'(res.emergency_on));
					check_field("is_homed", 32'(want.is_homed), 32'(res.is_homed));
					check_field("fused_valid", 32'(want.fused_valid), 32'(res.fused_valid));
					check_field("fused_cm", 32'(want.fused_cm), 32'(res.fused_cm));
				end
			end
			if (smp_fire)
				clearance_q.push_back(predict_step(sample_t'{smp.front_valid, smp.front_cm,
					smp.rear_valid, smp.rear_cm, smp.home_pressed, smp.emergency,
					smp.time_us, smp.time_ms}));
			if (smp_fire || (res.valid && res.ready) || (cfg_ch.valid && cfg_ch.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
	end

	// sample driver
	always @(negedge clk) begin
		sample_t beat;
		if (arst_n && (!smp.valid || smp_fire)) begin
			if (sample_q.size() != 0 && (no_idle || $urandom_range(99) >= 21)) begin
				beat = sample_q.pop_front();
				smp.front_valid <= beat.front_valid;
				smp.front_cm <= beat.front_cm;
				smp.rear_valid <= beat.rear_valid;
				smp.rear_cm <= beat.rear_cm;
				smp.home_pressed <= beat.home_pressed;
				smp.emergency <= beat.emergency;
				smp.time_us <= beat.time_us;
				smp.time_ms <= beat.time_ms;
				smp.valid <= 1'b1;
			end else begin
				smp.valid <= 1'b0;
			end
		end
	end

	// result receiver, with random ready and a single long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left = hold_left - 1;
			res.ready <= 1'b0;
		end else if (hold_seen != hold_asks) begin
			hold_seen = hold_asks;
			hold_left = HOLD_CYCLES;
			res.ready <= 1'b0;
		end else if (no_idle) begin
			res.ready <= 1'b1;
		end else begin
			res.ready <= ($urandom_range(99) >= 21);
		end
	end

	initial begin
		while (stall_cycles < STALL_LIMIT)
			@(negedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	function automatic sample_t make_sample(logic fv, logic [15:0] fcm, logic rv,
			logic [15:0] rcm, logic home, logic em, logic [31:0] dus, logic [31:0] dms);
		sample_t s;
		us_now = us_now + dus;
		ms_now = ms_now + dms;
		s.front_valid = fv;
		s.front_cm = fcm;
		s.rear_valid = rv;
		s.rear_cm = rcm;
		s.home_pressed = home;
		s.emergency = em;
		s.time_us = us_now;
		s.time_ms = ms_now;
		return s;
	endfunction

	task automatic wait_idle();
		while (sample_q.size() != 0 || smp.valid || clearance_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(logic [CFG_INDEX_WIDTH-1:0] idx, logic [15:0] data);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_TARGET_CM:
				if (data[5:0] >= TARGET_MIN && data[5:0] <= TARGET_MAX)
					regs_shadow.target_cm = data[5:0];
			REG_DEAD_ZONE_CM:      regs_shadow.dead_zone_cm = data[3:0];
			REG_FRONT_OFFSET_CM:   regs_shadow.front_offset_cm = data[7:0];
			REG_OVERRIDE_DELAY_MS: regs_shadow.override_delay_ms = data;
			REG_STEP_INTERVAL_US:  regs_shadow.step_interval_us = data;
			REG_BACKOFF_COUNT:     regs_shadow.backoff_count = data[7:0];
			default: ;
		endcase
	endtask

	task automatic configure(cfg_t c);
		wait_idle();
		reg_write(REG_TARGET_CM, {10'($urandom), c.target_cm});
		reg_write(REG_DEAD_ZONE_CM, {12'($urandom), c.dead_zone_cm});
		reg_write(REG_FRONT_OFFSET_CM, {8'($urandom), c.front_offset_cm});
		reg_write(REG_OVERRIDE_DELAY_MS, c.override_delay_ms);
		reg_write(REG_STEP_INTERVAL_US, c.step_interval_us);
		reg_write(REG_BACKOFF_COUNT, {8'($urandom), c.backoff_count});
		// out-of-range target is dropped
		reg_write(REG_TARGET_CM, ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(63, 50)));
		reg_write(REG_UNMAPPED, 16'($urandom));
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic offer_random(int count);
		int unsigned span_us, span_ms, roll;
		int top;
		logic fv, rv, home, em;
		logic [15:0] fcm, rcm;
		logic [31:0] dus, dms;
		for (int i = 0; i < count; i++) begin
			span_us = 2 * regs_shadow.step_interval_us + 2;
			span_ms = regs_shadow.override_delay_ms / 4 + 2;
			top = regs_shadow.target_cm + regs_shadow.dead_zone_cm + 20;
			if ($urandom_range(99) < 10) begin
				sample_q.push_back(make_sample(1'($urandom), 16'($urandom), 1'($urandom),
					16'($urandom), 1'($urandom), 1'($urandom), $urandom, $urandom));
			end else begin
				if ($urandom_range(99) < 5)
					level = $urandom_range(top);
				else
					level = level + $signed($urandom_range(6)) - 3;
				if (level < 0)
					level = 0;
				if (level > top)
					level = top;
				if ($urandom_range(9) == 0)
					fcm = 16'($urandom_range(regs_shadow.front_offset_cm));
				else
					fcm = 16'(level + regs_shadow.front_offset_cm + $urandom_range(2));
				rcm = 16'(level + $urandom_range(3));
				fv = ($urandom_range(9) < 8);
				rv = ($urandom_range(9) < 8);
				if (em_left > 0) begin
					em_left--;
					em = 1'b1;
					home = (em_left == 0) || ($urandom_range(9) == 0);
				end else begin
					if ($urandom_range(99) < 3)
						em_left = $urandom_range(8, 2);
					em = 1'b0;
					home = ($urandom_range(99) < 8);
				end
				roll = $urandom_range(99);
				if (roll < 80)
					dus = $urandom_range(span_us);
				else if (roll < 95)
					dus = $urandom_range(3);
				else
					dus = $urandom;
				roll = $urandom_range(99);
				if (roll < 85)
					dms = $urandom_range(span_ms);
				else if (roll < 97)
					dms = 32'd0;
				else
					dms = $urandom;
				sample_q.push_back(make_sample(fv, fcm, rv, rcm, home, em, dus, dms));
			end
		end
	endtask

	initial begin
		cfg_t c;
		arst_n = 1'b0;
		smp.valid = 1'b0;
		smp.front_valid = 1'b0;
		smp.front_cm = '0;
		smp.rear_valid = 1'b0;
		smp.rear_cm = '0;
		smp.home_pressed = 1'b0;
		smp.emergency = 1'b0;
		smp.time_us = '0;
		smp.time_ms = '0;
		res.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		us_now = $urandom;
		ms_now = $urandom;
		level = 0;
		em_left = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// homing: climb to the switch, then back off
		c = CFG_RESET;
		c.step_interval_us = 16'($urandom_range(50, 1));
		case ($urandom_range(3))
			0: c.backoff_count = 8'd0;
			1: c.backoff_count = 8'd255;
			default: c.backoff_count = 8'($urandom_range(30, 1));
		endcase
		configure(c);
		@(posedge clk);
		for (int i = 0; i < 6; i++)
			sample_q.push_back(make_sample(1'($urandom), 16'($urandom), 1'($urandom),
				16'($urandom), 1'b0, 1'($urandom),
				$urandom_range(2 * regs_shadow.step_interval_us), $urandom_range(20)));
		sample_q.push_back(make_sample(1'($urandom), 16'($urandom), 1'($urandom),
			16'($urandom), 1'b1, 1'($urandom), 5, 1));
		for (int i = 0; i < regs_shadow.backoff_count + 2; i++)
			sample_q.push_back(make_sample(1'b0, 16'($urandom), 1'b0, 16'($urandom),
				1'($urandom), 1'($urandom),
				regs_shadow.step_interval_us + $urandom_range(3), $urandom_range(20)));

		// directed checks of the control rules
		c = regs_shadow;
		c.target_cm = 6'd10;
		c.dead_zone_cm = 4'd2;
		c.front_offset_cm = 8'd5;
		c.override_delay_ms = 16'd100;
		c.step_interval_us = 16'd10;
		configure(c);
		@(posedge clk);
		sample_q.push_back(make_sample(1'b0, 16'd0, 1'b0, 16'd0, 1'b0, 1'b0, 20, 1));
		sample_q.push_back(make_sample(1'b1, 16'd0, 1'b0, 16'hFFFF, 1'b0, 1'b0, 20, 1));
		sample_q.push_back(make_sample(1'b1, 16'd3, 1'b0, 16'd0, 1'b1, 1'b0, 20, 1));
		sample_q.push_back(make_sample(1'b0, 16'hFFFF, 1'b1, 16'hFFFF, 1'b0, 1'b0, 20, 1));
		sample_q.push_back(make_sample(1'b1, 16'hFFFF, 1'b0, 16'd0, 1'b0, 1'b0, 20, 1));
		sample_q.push_back(make_sample(1'b1, 16'hFFFF, 1'b1, 16'hFFFF, 1'b0, 1'b0, 5, 50));
		sample_q.push_back(make_sample(1'b1, 16'd16, 1'b0, 16'd0, 1'b0, 1'b0, 20, 60));
		sample_q.push_back(make_sample(1'b0, 16'd0, 1'b1, 16'd10, 1'b0, 1'b0, 20, 1));
		sample_q.push_back(make_sample(1'b0, 16'd0, 1'b1, 16'd7, 1'b0, 1'b0, 20, 1));
		sample_q.push_back(make_sample(1'b0, 16'd0, 1'b1, 16'd8, 1'b0, 1'b0, 20, 1));
		sample_q.push_back(make_sample(1'b1, 16'd0, 1'b1, 16'd0, 1'b0, 1'b1, 20, 1));
		sample_q.push_back(make_sample(1'b1, 16'hFFFF, 1'b1, 16'hFFFF, 1'b0, 1'b1, 1, 1));
		sample_q.push_back(make_sample(1'b0, 16'd0, 1'b0, 16'd0, 1'b1, 1'b1, 20, 1));
		sample_q.push_back(make_sample(1'b1, 16'd30, 1'b1, 16'd40, 1'b0, 1'b0, 20, 1));
		// both timestamps wrap while stepping and timing
		sample_q.push_back(make_sample(1'b0, 16'd0, 1'b1, 16'd5, 1'b0, 1'b0,
			32'hFFFF_FFFA - us_now, 32'hFFFF_FFC0 - ms_now));
		sample_q.push_back(make_sample(1'b0, 16'd0, 1'b1, 16'd50, 1'b0, 1'b0, 20, 0));
		sample_q.push_back(make_sample(1'b0, 16'd0, 1'b1, 16'd50, 1'b0, 1'b0, 20, 32'h80));
		sample_q.push_back(make_sample(1'b0, 16'd0, 1'b1, 16'd50, 1'b1, 1'b0, 20, 1));

		for (int p = 0; p < 6; p++) begin
			c = regs_shadow;
			case (p)
				0: begin
					c.target_cm = TARGET_MIN;
					c.dead_zone_cm = 4'd0;
					c.front_offset_cm = 8'd0;
					c.override_delay_ms = 16'd0;
					c.step_interval_us = 16'd1;
				end
				1: begin
					c.target_cm = TARGET_MAX;
					c.dead_zone_cm = 4'd15;
					c.front_offset_cm = 8'd255;
					c.override_delay_ms = 16'hFFFF;
					c.step_interval_us = 16'hFFFF;
				end
				2: begin
					// dead zone at or past the target, no rate limit
					c.target_cm = 6'($urandom_range(15, 1));
					c.dead_zone_cm = 4'd15;
					c.front_offset_cm = 8'($urandom_range(40));
					c.override_delay_ms = 16'($urandom_range(500));
					c.step_interval_us = 16'd0;
				end
				default: begin
					c.target_cm = 6'($urandom);
					c.dead_zone_cm = 4'($urandom);
					c.front_offset_cm = ($urandom_range(1) == 0) ?
						8'($urandom_range(20)) : 8'($urandom);
					c.override_delay_ms = 16'($urandom_range(3000));
					c.step_interval_us = 16'($urandom_range(3000, 1));
					c.backoff_count = 8'($urandom);
				end
			endcase
			configure(c);
			@(posedge clk);
			no_idle = (p == 4);
			level = regs_shadow.target_cm;
			offer_random(PHASE_ITEMS);
			if (p == 3)
				hold_asks++;
		end

		wait_idle();
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
